// ----- sv/ws2812_pkg.sv -----
// ----------------------------------------------------------------------------
// ws2812_pkg
// Shared types and constants for the one-wire LED pixel serializer: request
// codes, configuration register indexes, reset values and the control and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ws2812_pkg;

  // Width of the phase tick counters unless overridden at the top level.
  localparam int unsigned TimingBitsDefault = 8;

  // Fixed field widths.
  localparam int unsigned ColorW   = 8;
  localparam int unsigned HourW    = 5;
  localparam int unsigned BrightW  = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned PixelW   = 24;
  localparam int unsigned BitCntW  = 5;
  localparam int unsigned ProdW    = ColorW + BrightW;
  localparam int unsigned NightW   = ProdW + 6;

  // Number of bits sent for one pixel.
  localparam logic [BitCntW-1:0] PixelBits = 5'd24;

  // Night window: hour at or above the start, or below the end.
  localparam logic [HourW-1:0] NightStartHour = 5'd22;
  localparam logic [HourW-1:0] NightEndHour   = 5'd6;

  // Register reset values.
  localparam logic [BrightW-1:0] BrightnessReset = 9'd256;
  localparam logic [7:0]         ZeroHighReset   = 8'd20;
  localparam logic [7:0]         ZeroLowReset    = 8'd38;
  localparam logic [7:0]         OneHighReset    = 8'd38;
  localparam logic [7:0]         OneLowReset     = 8'd5;

  // Request kinds carried in the mode field.
  typedef enum logic {
    ModePixel = 1'b0,
    ModeTick  = 1'b1
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgBrightness = 3'd0,
    CfgZeroHigh   = 3'd1,
    CfgZeroLow    = 3'd2,
    CfgOneHigh    = 3'd3,
    CfgOneLow     = 3'd4
  } cfg_idx_e;

  // Color lane being scaled.
  typedef enum logic [1:0] {
    LaneGreen = 2'd0,
    LaneRed   = 2'd1,
    LaneBlue  = 2'd2
  } lane_e;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StMul  = 2'd1,
    StAcc  = 2'd2,
    StLoad = 2'd3
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch pixel fields and night flag, restart lanes
    logic mul;        // brightness product of the current lane
    logic acc;        // night scale, saturate, append to the word
    logic load;       // load the scaled word into the shifter
    logic tick;       // advance the waveform by one time unit
    logic out_write;  // write the result register
    logic drop;       // the result flags a dropped pixel
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;       // bits remain to be sent
    logic last_lane;  // the blue lane is current
  } dp_status_t;

endpackage

// ----- sv/ws2812_ctrl.sv -----
// ----------------------------------------------------------------------------
// ws2812_ctrl
// Controller of the serializer: accepts requests, sequences the three-lane
// color scaling and owns the valid bit of the result register.
// ----------------------------------------------------------------------------
module ws2812_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ws2812_pkg::dp_status_t status_i,
  output ws2812_pkg::dp_cmd_t    cmd_o
);
  import ws2812_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        accept;

  // The result register can take a new value when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (mode_i == ModePixel) && !status_i.busy) begin
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StAcc;
      end
      StAcc: begin
        state_d = status_i.last_lane ? StLoad : StMul;
      end
      StLoad: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (mode_i == ModeTick) begin
            cmd_o.tick      = 1'b1;
            cmd_o.out_write = 1'b1;
          end else if (status_i.busy) begin
            cmd_o.drop      = 1'b1;
            cmd_o.out_write = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
          end
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
      end
      StLoad: begin
        if (out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.out_write = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  // Result valid: set on a write, cleared when the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_write) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/ws2812_dp.sv -----
// ----------------------------------------------------------------------------
// ws2812_dp
// Datapath of the serializer: configuration registers, the shared color
// scaling unit, the 24-bit shifter with its phase counter and the result
// register payload.
// ----------------------------------------------------------------------------
module ws2812_dp #(
  parameter int unsigned TIMING_BITS = ws2812_pkg::TimingBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ws2812_pkg::ColorW-1:0]     green_i,
  input  logic [ws2812_pkg::ColorW-1:0]     red_i,
  input  logic [ws2812_pkg::ColorW-1:0]     blue_i,
  input  logic [ws2812_pkg::HourW-1:0]      hour_i,
  input  logic                              cfg_we_i,
  input  logic [ws2812_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ws2812_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  ws2812_pkg::dp_cmd_t               cmd_i,
  output ws2812_pkg::dp_status_t            status_o,
  output logic                              pin_level_o,
  output logic                              busy_res_o,
  output logic                              pixel_dropped_o
);
  import ws2812_pkg::*;

  // Configuration registers.
  logic [BrightW-1:0]     brightness_q;
  logic [TIMING_BITS-1:0] zero_high_q, zero_low_q, one_high_q, one_low_q;
  logic [TIMING_BITS-1:0] cfg_tick_val;
  logic [TIMING_BITS+7:0] cfg_tick_ext;

  // Scaling unit.
  logic [ColorW-1:0]      green_q, red_q, blue_q;
  logic                   night_q;
  lane_e                  lane_q;
  logic [ColorW-1:0]      lane_color;
  logic [ProdW-1:0]       prod_q;
  logic [NightW-1:0]      prod_ext, night_prod;
  logic [ColorW-1:0]      scaled;
  logic [PixelW-1:0]      word_q;

  // Shifter and phase timing.
  logic [PixelW-1:0]      shift_q, shift_d;
  logic [BitCntW-1:0]     bits_q, bits_d, bits_dec;
  logic                   high_q, high_d;
  logic [TIMING_BITS-1:0] ticks_q, ticks_d;

  // Result payload.
  logic pin_q, busy_q, drop_q;

  // Tick counts arrive as 8 bits and are kept at the counter width.
  assign cfg_tick_ext = {{TIMING_BITS{1'b0}}, cfg_wdata_i[7:0]};
  assign cfg_tick_val = cfg_tick_ext[TIMING_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BrightnessReset;
      zero_high_q  <= TIMING_BITS'(ZeroHighReset);
      zero_low_q   <= TIMING_BITS'(ZeroLowReset);
      one_high_q   <= TIMING_BITS'(OneHighReset);
      one_low_q    <= TIMING_BITS'(OneLowReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBrightness: brightness_q <= cfg_wdata_i;
        CfgZeroHigh:   zero_high_q  <= cfg_tick_val;
        CfgZeroLow:    zero_low_q   <= cfg_tick_val;
        CfgOneHigh:    one_high_q   <= cfg_tick_val;
        CfgOneLow:     one_low_q    <= cfg_tick_val;
        default: ;
      endcase
    end
  end

  // Pixel capture and lane stepping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= LaneGreen;
    end else if (cmd_i.capture) begin
      lane_q <= LaneGreen;
    end else if (cmd_i.acc) begin
      lane_q <= (lane_q == LaneGreen) ? LaneRed : LaneBlue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      green_q <= green_i;
      red_q   <= red_i;
      blue_q  <= blue_i;
      night_q <= (hour_i >= NightStartHour) || (hour_i < NightEndHour);
    end
  end

  always_comb begin
    unique case (lane_q)
      LaneGreen: lane_color = green_q;
      LaneRed:   lane_color = red_q;
      default:   lane_color = blue_q;
    endcase
  end

  // First stage: color times brightness.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= ProdW'(lane_color) * ProdW'(brightness_q);
    end
  end

  // Second stage: night scaling by 51/256 as shifts and adds; by day the product saturates.
  assign prod_ext   = NightW'(prod_q);
  assign night_prod = (prod_ext << 5) + (prod_ext << 4) + (prod_ext << 1) + prod_ext;

  always_comb begin
    if (night_q) begin
      scaled = {1'b0, night_prod[NightW-1:16]};
    end else if (prod_q[ProdW-1]) begin
      scaled = '1;
    end else begin
      scaled = prod_q[ProdW-2:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      word_q <= {word_q[PixelW-ColorW-1:0], scaled};
    end
  end

  // Waveform sequencing: load a word or advance by one tick.
  assign bits_dec = bits_q - 5'd1;

  always_comb begin
    shift_d = shift_q;
    bits_d  = bits_q;
    high_d  = high_q;
    ticks_d = ticks_q;
    if (cmd_i.load) begin
      shift_d = word_q;
      bits_d  = PixelBits;
      high_d  = 1'b1;
      ticks_d = word_q[PixelW-1] ? one_high_q : zero_high_q;
    end else if (cmd_i.tick && (bits_q != '0)) begin
      if (ticks_q > TIMING_BITS'(1)) begin
        ticks_d = ticks_q - TIMING_BITS'(1);
      end else if (high_q) begin
        high_d  = 1'b0;
        ticks_d = shift_q[PixelW-1] ? one_low_q : zero_low_q;
      end else begin
        shift_d = {shift_q[PixelW-2:0], 1'b0};
        bits_d  = bits_dec;
        if (bits_dec != '0) begin
          high_d  = 1'b1;
          ticks_d = shift_q[PixelW-2] ? one_high_q : zero_high_q;
        end else begin
          high_d  = 1'b0;
          ticks_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      bits_q  <= '0;
      high_q  <= 1'b0;
      ticks_q <= '0;
    end else begin
      shift_q <= shift_d;
      bits_q  <= bits_d;
      high_q  <= high_d;
      ticks_q <= ticks_d;
    end
  end

  // Result payload, taken from the state as it stands after this request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_write) begin
      pin_q  <= (bits_d != '0) && high_d;
      busy_q <= bits_d != '0;
      drop_q <= cmd_i.drop;
    end
  end

  assign status_o.busy      = bits_q != '0;
  assign status_o.last_lane = lane_q == LaneBlue;

  assign pin_level_o     = pin_q;
  assign busy_res_o      = busy_q;
  assign pixel_dropped_o = drop_q;

endmodule

// ----- sv/ws2812_pixel_serializer_core.sv -----
// ----------------------------------------------------------------------------
// ws2812_pixel_serializer_core
// One-wire LED pixel encoder: scales a pixel by brightness and night dimming,
// then sends its 24 bits as timed high and low phases, one tick per request.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   -------------------------------------
//   in        in_valid_i / in_ready_o   mode_i, green_i, red_i, blue_i, hour_i
//   out       out_valid_o / out_ready_i pin_level_o, busy_res_o,
//                                       pixel_dropped_o
//   cfg       cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// A tick request, and a pixel that arrives while busy, write a result when
// taken; ticks can follow each other every cycle while the consumer keeps up.
// A loaded pixel is accepted, then takes its three lanes in turn through the
// shared multiplier and night scaler, a multiply and an accumulate state per
// lane, then the load state, which waits while the result register is full.
// The single result register limits throughput: in_ready_o drops while a
// result waits and out_ready_i is low.
// Reset restores the register defaults, empties the shifter and clears out_valid_o.
//
module ws2812_pixel_serializer_core #(
  parameter int unsigned TIMING_BITS = ws2812_pkg::TimingBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [ws2812_pkg::ColorW-1:0]   green_i,
  input  logic [ws2812_pkg::ColorW-1:0]   red_i,
  input  logic [ws2812_pkg::ColorW-1:0]   blue_i,
  input  logic [ws2812_pkg::HourW-1:0]    hour_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            pin_level_o,
  output logic                            busy_res_o,
  output logic                            pixel_dropped_o,
  input  logic                            cfg_we_i,
  input  logic [ws2812_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ws2812_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import ws2812_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Request sequencing.
  ws2812_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Scaling, shifting and waveform timing.
  ws2812_dp #(
    .TIMING_BITS (TIMING_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .green_i         (green_i),
    .red_i           (red_i),
    .blue_i          (blue_i),
    .hour_i          (hour_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .pin_level_o     (pin_level_o),
    .busy_res_o      (busy_res_o),
    .pixel_dropped_o (pixel_dropped_o)
  );

endmodule

// ----- sv/ws2812_chk.sv -----
// ----------------------------------------------------------------------------
// ws2812_chk
// Port-level checks of the serializer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ws2812_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic pin_level_o,
  input logic busy_res_o,
  input logic pixel_dropped_o
);

  // A pending result is not withdrawn before it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // A new request is only taken when the result register has room.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("request taken while the result register is full");

  // The pin is only driven high while a pixel is in flight.
  a_pin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pin_level_o |-> busy_res_o)
    else $error("pin high while idle");

  // A pixel is only dropped while another is being sent.
  a_drop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_dropped_o |-> busy_res_o)
    else $error("pixel dropped while idle");

endmodule

bind ws2812_pixel_serializer_core ws2812_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .pin_level_o     (pin_level_o),
  .busy_res_o      (busy_res_o),
  .pixel_dropped_o (pixel_dropped_o)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the one-wire LED pixel serializer. Pixel and
// tick requests go in over a valid/ready channel while the line level, busy
// flag and drop flag come back one result per request. A cycle-free model of
// the scaling and bit timing predicts every result. A short table of directed
// rows comes first. Random phases follow, each with its own register setting
// and its own amount of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ws2812_pkg::*;

  // Night dimming stands in for 0.2 as 51/256.
  localparam int unsigned NightNum    = 51;
  // Cycles to let pass after the last result before touching registers.
  localparam int unsigned SettleCycles = 16;
  // Length of the long receiver hold-off.
  localparam int unsigned LongStall   = 150;
  // A register index past the end of the map; writes to it are ignored.
  localparam logic [CfgIdxW-1:0] CfgUnmappedIdx = 3'd7;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned PressurePhase = 5;

  typedef struct packed {
    mode_e             mode;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] blue;
    logic [HourW-1:0]  hour;
  } pixel_req_t;

  typedef struct packed {
    logic pin_level;
    logic busy;
    logic dropped;
  } line_state_t;

  typedef struct packed {
    logic                is_write;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_data;
    pixel_req_t          req;
    logic [7:0]          reps;
    logic                typed;
    line_state_t         typed_res;
  } plan_row_t;

  typedef struct packed {
    logic [BrightW-1:0] bright;
    logic [7:0]         zero_high;
    logic [7:0]         zero_low;
    logic [7:0]         one_high;
    logic [7:0]         one_low;
    logic [10:0]        items;
    logic [6:0]         send_idle;
    logic [6:0]         recv_idle;
  } reg_plan_t;

  // Block ports.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                mode_i      = 1'b0;
  logic [ColorW-1:0]   green_i     = '0;
  logic [ColorW-1:0]   red_i       = '0;
  logic [ColorW-1:0]   blue_i      = '0;
  logic [HourW-1:0]    hour_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                pin_level_o;
  logic                busy_res_o;
  logic                pixel_dropped_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Register copies and serializer state of the prediction.
  logic [BrightW-1:0] brightness_q;
  logic [7:0]         zero_high_q;
  logic [7:0]         zero_low_q;
  logic [7:0]         one_high_q;
  logic [7:0]         one_low_q;
  logic [PixelW-1:0]  word_sr;
  logic [BitCntW-1:0] bits_to_send;
  logic               high_phase;
  logic [7:0]         phase_left;

  line_state_t expected_lines [$];
  line_state_t seen_line;
  int unsigned error_count    = 0;
  int unsigned result_count   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served   = 0;
  int unsigned stall_left     = 0;

  always #5 clk_i = ~clk_i;

  ws2812_pixel_serializer_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .green_i        (green_i),
    .red_i          (red_i),
    .blue_i         (blue_i),
    .hour_i         (hour_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pin_level_o    (pin_level_o),
    .busy_res_o     (busy_res_o),
    .pixel_dropped_o(pixel_dropped_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Brightness scaling of one color, with night dimming and saturation.
  function automatic logic [ColorW-1:0] scale_lane(logic [ColorW-1:0] level,
                                                   logic [HourW-1:0] hour);
    int unsigned prod;
    prod = level * brightness_q;
    if (hour >= NightStartHour || hour < NightEndHour) begin
      prod = (prod * NightNum) >> 16;
    end else begin
      prod = prod >> 8;
    end
    return (prod > 255) ? 8'hFF : 8'(prod);
  endfunction

  // Start the high part of the bit now at the top of the word.
  function automatic void begin_high();
    high_phase = 1'b1;
    phase_left = word_sr[PixelW-1] ? one_high_q : zero_high_q;
  endfunction

  // Advance the predicted serializer by one request and return its result.
  function automatic line_state_t serializer_step(pixel_req_t req);
    line_state_t res;
    res.dropped = 1'b0;
    if (req.mode == ModePixel) begin
      if (bits_to_send != 0) begin
        res.dropped = 1'b1;
      end else begin
        word_sr = {scale_lane(req.green, req.hour), scale_lane(req.red, req.hour),
                   scale_lane(req.blue, req.hour)};
        bits_to_send = PixelBits;
        begin_high();
      end
    end else if (bits_to_send != 0) begin
      if (phase_left > 1) begin
        phase_left = phase_left - 1'b1;
      end else if (high_phase) begin
        high_phase = 1'b0;
        phase_left = word_sr[PixelW-1] ? one_low_q : zero_low_q;
      end else begin
        word_sr = word_sr << 1;
        bits_to_send = bits_to_send - 1'b1;
        if (bits_to_send != 0) begin
          begin_high();
        end else begin
          high_phase = 1'b0;
          phase_left = '0;
        end
      end
    end
    res.pin_level = (bits_to_send != 0) && high_phase;
    res.busy = bits_to_send != 0;
    return res;
  endfunction

  // Register write as the block sees it.
  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    unique case (idx)
      CfgBrightness: brightness_q = data;
      CfgZeroHigh:   zero_high_q = data[7:0];
      CfgZeroLow:    zero_low_q = data[7:0];
      CfgOneHigh:    one_high_q = data[7:0];
      CfgOneLow:     one_low_q = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic plan_row_t item_row(mode_e mode, logic [ColorW-1:0] g,
                                         logic [ColorW-1:0] r, logic [ColorW-1:0] b,
                                         logic [HourW-1:0] hour, logic [7:0] reps);
    plan_row_t row;
    row = '0;
    row.req = '{mode: mode, green: g, red: r, blue: b, hour: hour};
    row.reps = reps;
    return row;
  endfunction

  function automatic plan_row_t typed_row(plan_row_t row, logic pin, logic busy,
                                          logic dropped);
    row.typed = 1'b1;
    row.typed_res = '{pin_level: pin, busy: busy, dropped: dropped};
    return row;
  endfunction

  function automatic plan_row_t write_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  // Colors lean toward the extremes.
  function automatic logic [ColorW-1:0] pick_level();
    unique case ($urandom_range(0, 6))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // While a pixel is on the line most requests are ticks; when idle most are pixels.
  function automatic pixel_req_t random_request();
    pixel_req_t req;
    req.green = pick_level();
    req.red = pick_level();
    req.blue = pick_level();
    req.hour = 5'($urandom_range(0, 31));
    if (bits_to_send != 0) begin
      req.mode = ($urandom_range(0, 9) == 0) ? ModePixel : ModeTick;
    end else begin
      req.mode = ($urandom_range(0, 99) < 65) ? ModePixel : ModeTick;
    end
    return req;
  endfunction

  // Offer one request, wait for it to be taken and predict its result.
  task automatic send_request(input pixel_req_t req, output line_state_t predicted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= req.mode;
    green_i <= req.green;
    red_i <= req.red;
    blue_i <= req.blue;
    hour_i <= req.hour;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = serializer_step(req);
  endtask

  // Stop offering and wait until every result is back and the block is quiet.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    apply_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, plus one long hold-off when asked.
  always @(posedge clk_i) begin
    if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      stall_left = LongStall;
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_line.pin_level = pin_level_o;
      seen_line.busy = busy_res_o;
      seen_line.dropped = pixel_dropped_o;
      if (expected_lines.size() == 0) begin
        if (error_count < 10) begin
          $display("result %0d arrived with nothing pending: pin %b busy %b dropped %b",
                   result_count, seen_line.pin_level, seen_line.busy, seen_line.dropped);
        end
        error_count++;
      end else if (seen_line !== expected_lines[0]) begin
        if (error_count < 10) begin
          $display("result %0d mismatch: expected pin %b busy %b dropped %b, got %b %b %b",
                   result_count, expected_lines[0].pin_level, expected_lines[0].busy,
                   expected_lines[0].dropped, seen_line.pin_level, seen_line.busy,
                   seen_line.dropped);
        end
        error_count++;
        void'(expected_lines.pop_front());
      end else begin
        void'(expected_lines.pop_front());
      end
      result_count++;
    end
  end

  // Hard limit on the run length.
  initial begin
    #2ms;
    $display("ws2812_pixel_serializer_core regression: fail");
    $finish;
  end

  // Stimulus: directed rows, then random phases.
  initial begin
    plan_row_t   directed_plan [$];
    reg_plan_t   phase_plan [PhaseCount];
    line_state_t predicted;
    pixel_req_t  req;

    brightness_q = BrightnessReset;
    zero_high_q = ZeroHighReset;
    zero_low_q = ZeroLowReset;
    one_high_q = OneHighReset;
    one_low_q = OneLowReset;
    word_sr = '0;
    bits_to_send = '0;
    high_phase = 1'b0;
    phase_left = '0;

    // All timing at zero, so every phase lasts one tick and a pixel takes 48.
    directed_plan.push_back(typed_row(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd1),
                                      1'b0, 1'b0, 1'b0));
    directed_plan.push_back(write_row(CfgZeroHigh, 9'd0));
    directed_plan.push_back(write_row(CfgZeroLow, 9'd0));
    directed_plan.push_back(write_row(CfgOneHigh, 9'd0));
    directed_plan.push_back(write_row(CfgOneLow, 9'd0));
    directed_plan.push_back(write_row(CfgUnmappedIdx, 9'h1FF));
    directed_plan.push_back(typed_row(item_row(ModePixel, 8'hFF, 8'h00, 8'hAA, 5'd12, 8'd1),
                                      1'b1, 1'b1, 1'b0));
    directed_plan.push_back(typed_row(item_row(ModePixel, 8'h12, 8'h34, 8'h56, 5'd3, 8'd1),
                                      1'b1, 1'b1, 1'b1));
    directed_plan.push_back(item_row(ModeTick, 8'hFF, 8'hFF, 8'hFF, 5'd31, 8'd48));
    directed_plan.push_back(typed_row(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd1),
                                      1'b0, 1'b0, 1'b0));
    // Night and day boundaries, and hours past 23.
    directed_plan.push_back(item_row(ModePixel, 8'hFF, 8'hFF, 8'hFF, 5'd22, 8'd1));
    directed_plan.push_back(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd48));
    directed_plan.push_back(item_row(ModePixel, 8'h80, 8'h7F, 8'h01, 5'd5, 8'd1));
    directed_plan.push_back(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd48));
    directed_plan.push_back(item_row(ModePixel, 8'hFF, 8'h55, 8'hAA, 5'd6, 8'd1));
    directed_plan.push_back(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd48));
    directed_plan.push_back(item_row(ModePixel, 8'h55, 8'hAA, 8'hFF, 5'd31, 8'd1));
    directed_plan.push_back(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd48));
    // Brightness at zero, far above full scale, and barely above zero at night.
    directed_plan.push_back(write_row(CfgBrightness, 9'd0));
    directed_plan.push_back(item_row(ModePixel, 8'hFF, 8'hFF, 8'hFF, 5'd12, 8'd1));
    directed_plan.push_back(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd48));
    directed_plan.push_back(write_row(CfgBrightness, 9'h1FF));
    directed_plan.push_back(item_row(ModePixel, 8'hC0, 8'h81, 8'h7F, 5'd24, 8'd1));
    directed_plan.push_back(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd48));
    directed_plan.push_back(item_row(ModePixel, 8'hC0, 8'h81, 8'h7F, 5'd21, 8'd1));
    directed_plan.push_back(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd48));
    directed_plan.push_back(write_row(CfgBrightness, 9'd1));
    directed_plan.push_back(item_row(ModePixel, 8'hFF, 8'hFF, 8'hFF, 5'd23, 8'd1));
    directed_plan.push_back(item_row(ModeTick, 8'h00, 8'h00, 8'h00, 5'd0, 8'd48));

    // Register settings per phase; the idle mix moves from receiver-heavy idling
    // to sender-heavy idling to none at all.
    phase_plan[0] = '{9'd256, 8'd1, 8'd2, 8'd2, 8'd1, 11'd130, 7'd37, 7'd52};
    phase_plan[1] = '{9'd511, 8'd0, 8'd0, 8'd0, 8'd0, 11'd120, 7'd37, 7'd52};
    phase_plan[2] = '{9'd255, 8'd255, 8'd255, 8'd255, 8'd255, 11'd100, 7'd52, 7'd37};
    phase_plan[3] = '{9'd0, 8'd3, 8'd1, 8'd1, 8'd3, 11'd110, 7'd52, 7'd37};
    phase_plan[4] = '{9'd128, 8'd4, 8'd7, 8'd7, 8'd2, 11'd100, 7'd0, 7'd0};
    phase_plan[5] = '{9'd256, 8'd1, 8'd1, 8'd1, 8'd1, 11'd95, 7'd0, 7'd0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 52;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_write) begin
        drain_results();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_data);
      end else begin
        for (int n = 0; n < directed_plan[i].reps; n++) begin
          send_request(directed_plan[i].req, predicted);
          expected_lines.push_back(directed_plan[i].typed ? directed_plan[i].typed_res
                                                          : predicted);
        end
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      write_reg(CfgBrightness, phase_plan[p].bright);
      write_reg(CfgZeroHigh, CfgDataW'(phase_plan[p].zero_high));
      write_reg(CfgZeroLow, CfgDataW'(phase_plan[p].zero_low));
      write_reg(CfgOneHigh, CfgDataW'(phase_plan[p].one_high));
      write_reg(CfgOneLow, CfgDataW'(phase_plan[p].one_low));
      send_idle_pct = phase_plan[p].send_idle;
      recv_idle_pct = phase_plan[p].recv_idle;
      // Hold the receiver off so the result register fills and the input stalls.
      if (p == PressurePhase) begin
        stall_requests++;
      end
      for (int n = 0; n < phase_plan[p].items; n++) begin
        req = random_request();
        send_request(req, predicted);
        expected_lines.push_back(predicted);
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("ws2812_pixel_serializer_core regression: pass");
    end else begin
      $display("ws2812_pixel_serializer_core regression: fail");
    end
    $finish;
  end

endmodule
